// ===== rtl/pid_integral_separation_macros.svh =====
// Assertion helpers for the PID block.
// Define NO_ASSERTIONS to compile them out.
`ifndef PID_INTEGRAL_SEPARATION_MACROS_SVH
`define PID_INTEGRAL_SEPARATION_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/pid_is_pkg.sv =====
package pid_is_pkg;

	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned SEP_W   = 15;
	localparam int unsigned LIM_W   = 20;
	localparam int unsigned ERR_W   = 17;
	localparam int unsigned DIFF_W  = 18;
	localparam int unsigned INTEG_W = 21;
	localparam int unsigned P_W     = 34;
	localparam int unsigned I_W     = 38;
	localparam int unsigned D_W     = 35;
	localparam int unsigned SUM_W   = 39;
	localparam int unsigned OUT_W   = 32;
	localparam int unsigned FRAC_W  = 8;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned CFG_W   = 20;

	localparam logic [7:0]  ARM_CODE     = 8'h0A;
	localparam logic [11:0] THROTTLE_MIN = 12'd200;

	typedef enum logic [IDX_W-1:0] {
		REG_P_GAIN    = 3'd0,
		REG_I_GAIN    = 3'd1,
		REG_D_GAIN    = 3'd2,
		REG_SEP_LIMIT = 3'd3,
		REG_INT_LIMIT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] p_gain;
		logic [GAIN_W-1:0] i_gain;
		logic [GAIN_W-1:0] d_gain;
		logic [SEP_W-1:0]  sep_limit;
		logic [LIM_W-1:0]  int_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]   error;
		logic signed [DIFF_W-1:0]  differ;
		logic signed [INTEG_W-1:0] integral;
		logic                      integ;
	} s1_t;

	typedef struct packed {
		logic signed [P_W-1:0] p_full;
		logic signed [I_W-1:0] i_full;
		logic signed [D_W-1:0] d_full;
		logic                  integ;
	} s2_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] drive;
		logic signed [OUT_W-1:0] p_term;
		logic signed [OUT_W-1:0] i_term;
		logic signed [OUT_W-1:0] d_term;
		logic                    integrating;
	} res_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]   prev_error;
		logic signed [INTEG_W-1:0] integral;
	} stat_t;

endpackage

// ===== rtl/pid_is_if.sv =====
interface pid_is_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] target;
	logic signed [15:0] measure;
	logic [7:0]         arm_code;
	logic [11:0]        throttle;

	modport source (output valid, target, measure, arm_code, throttle, input ready);
	modport sink (input valid, target, measure, arm_code, throttle, output ready);
endinterface

interface pid_is_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;
	logic signed [31:0] p_term;
	logic signed [31:0] i_term;
	logic signed [31:0] d_term;
	logic               integrating;

	modport source (output valid, drive, p_term, i_term, d_term, integrating, input ready);
	modport sink (input valid, drive, p_term, i_term, d_term, integrating, output ready);
endinterface

interface pid_is_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [19:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pid_is_front.sv =====
module pid_is_front (
	input  logic              clk,
	input  logic              arst_n,
	pid_is_in_if.sink         sample,
	input  pid_is_pkg::cfg_t  cfg_regs,
	output logic              valid_s1,
	input  logic              nxt_ready,
	output pid_is_pkg::s1_t   data_s1,
	output pid_is_pkg::stat_t stat
);
	import pid_is_pkg::*;

	logic                      accept;
	logic                      armed;
	logic                      in_band;
	logic signed [ERR_W-1:0]   meas_x;
	logic signed [ERR_W-1:0]   sep_x;
	logic signed [ERR_W-1:0]   error;
	logic signed [DIFF_W-1:0]  differ;
	logic signed [INTEG_W:0]   acc;
	logic signed [INTEG_W:0]   lim_x;
	logic signed [INTEG_W:0]   lim_neg;
	logic signed [INTEG_W-1:0] integral_nxt;
	logic signed [ERR_W-1:0]   prev_error_q;
	logic signed [INTEG_W-1:0] integral_q;

	assign sample.ready = !valid_s1 || nxt_ready;
	assign accept       = sample.valid && sample.ready;

	assign armed   = (sample.arm_code == ARM_CODE) && (sample.throttle >= THROTTLE_MIN);
	assign meas_x  = {sample.measure[15], sample.measure};
	assign sep_x   = $signed({2'b00, cfg_regs.sep_limit});
	assign in_band = (meas_x <= sep_x) && (meas_x >= -sep_x);
	assign error   = {sample.target[15], sample.target} - meas_x;
	assign differ  = {error[ERR_W-1], error} - {prev_error_q[ERR_W-1], prev_error_q};
	assign acc     = {integral_q[INTEG_W-1], integral_q}
		+ {{(INTEG_W+1-ERR_W){error[ERR_W-1]}}, error};
	assign lim_x   = $signed({2'b00, cfg_regs.int_limit});
	assign lim_neg = -lim_x;

	// The clamped sum always fits the integral register since the limit has 20 bits.
	always_comb begin
		if (!armed) begin
			integral_nxt = '0;
		end else if (!in_band) begin
			integral_nxt = integral_q;
		end else if (acc > lim_x) begin
			integral_nxt = lim_x[INTEG_W-1:0];
		end else if (acc < lim_neg) begin
			integral_nxt = lim_neg[INTEG_W-1:0];
		end else begin
			integral_nxt = acc[INTEG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			prev_error_q <= '0;
			integral_q   <= '0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (accept) begin
				prev_error_q <= error;
				integral_q   <= integral_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.error    <= error;
			data_s1.differ   <= differ;
			data_s1.integral <= integral_nxt;
			data_s1.integ    <= armed && in_band;
		end
	end

	assign stat.prev_error = prev_error_q;
	assign stat.integral   = integral_q;
endmodule

// ===== rtl/pid_is_mult.sv =====
module pid_is_mult (
	input  logic             clk,
	input  logic             arst_n,
	input  pid_is_pkg::cfg_t cfg_regs,
	input  logic             valid_s1,
	output logic             ready_s1,
	input  pid_is_pkg::s1_t  data_s1,
	output logic             valid_s2,
	input  logic             nxt_ready,
	output pid_is_pkg::s2_t  data_s2
);
	import pid_is_pkg::*;

	logic signed [P_W-1:0] p_full;
	logic signed [I_W-1:0] i_prod;
	logic signed [I_W-1:0] i_full;
	logic signed [D_W-1:0] d_full;

	assign ready_s1 = !valid_s2 || nxt_ready;

	// Gains are unsigned, so each gets a zero sign bit before the signed multiply.
	assign p_full = $signed({1'b0, cfg_regs.p_gain}) * data_s1.error;
	assign i_prod = $signed({1'b0, cfg_regs.i_gain}) * data_s1.integral;
	assign i_full = data_s1.integ ? i_prod : '0;
	assign d_full = $signed({1'b0, cfg_regs.d_gain}) * data_s1.differ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			data_s2.p_full <= p_full;
			data_s2.i_full <= i_full;
			data_s2.d_full <= d_full;
			data_s2.integ  <= data_s1.integ;
		end
	end
endmodule

// ===== rtl/pid_is_out.sv =====
module pid_is_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s2,
	output logic            ready_s2,
	input  pid_is_pkg::s2_t data_s2,
	pid_is_out_if.source    result
);
	import pid_is_pkg::*;

	logic                    valid_s3;
	res_t                    res_s3;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] sum_sh;
	logic signed [P_W-1:0]   p_sh;
	logic signed [I_W-1:0]   i_sh;
	logic signed [D_W-1:0]   d_sh;
	logic signed [OUT_W-1:0] drive;

	assign ready_s2 = !valid_s3 || result.ready;

	assign sum = {{(SUM_W-P_W){data_s2.p_full[P_W-1]}}, data_s2.p_full}
		+ {{(SUM_W-I_W){data_s2.i_full[I_W-1]}}, data_s2.i_full}
		+ {{(SUM_W-D_W){data_s2.d_full[D_W-1]}}, data_s2.d_full};
	assign sum_sh = sum >>> FRAC_W;
	assign p_sh   = data_s2.p_full >>> FRAC_W;
	assign i_sh   = data_s2.i_full >>> FRAC_W;
	assign d_sh   = data_s2.d_full >>> FRAC_W;

	// The shifted sum fits 32 bits only when bit 31 and all bits above it match its sign.
	always_comb begin
		if (!sum_sh[SUM_W-1] && (sum_sh[SUM_W-2:OUT_W-1] != '0)) begin
			drive = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (sum_sh[SUM_W-1] && (sum_sh[SUM_W-2:OUT_W-1] != '1)) begin
			drive = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			drive = sum_sh[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			res_s3.drive       <= drive;
			res_s3.p_term      <= p_sh[OUT_W-1:0];
			res_s3.i_term      <= i_sh[OUT_W-1:0];
			res_s3.d_term      <= d_sh[OUT_W-1:0];
			res_s3.integrating <= data_s2.integ;
		end
	end

	assign result.valid       = valid_s3;
	assign result.drive       = res_s3.drive;
	assign result.p_term      = res_s3.p_term;
	assign result.i_term      = res_s3.i_term;
	assign result.d_term      = res_s3.d_term;
	assign result.integrating = res_s3.integrating;
endmodule

// ===== rtl/pid_integral_separation.sv =====
// Channel  Role    Payload
// sample   sink    target, measure, arm_code, throttle
// result   source  drive, p_term, i_term, d_term, integrating
// cfg      sink    index, data (register write, always ready)
//
// One sample per cycle unless the result side holds the pipeline back. The three registered
// stages are error and integral update, the three multiplies, then the sum with saturation
// into the output register.
// Each stage stalls only when it is full and the next stage cannot take its contents.
// Reset clears the gains, limits, previous error and integral to zero.
`include "pid_integral_separation_macros.svh"

module pid_integral_separation (
	input  logic         clk,
	input  logic         arst_n,
	pid_is_in_if.sink    sample,
	pid_is_out_if.source result,
	pid_is_cfg_if.sink   cfg
);
	import pid_is_pkg::*;

	cfg_t  cfg_q;
	stat_t stat;
	logic  valid_s1;
	logic  ready_s1;
	s1_t   data_s1;
	logic  valid_s2;
	logic  ready_s2;
	s2_t   data_s2;
	logic  accept;
	logic  armed;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_P_GAIN:    cfg_q.p_gain    <= cfg.data[GAIN_W-1:0];
				REG_I_GAIN:    cfg_q.i_gain    <= cfg.data[GAIN_W-1:0];
				REG_D_GAIN:    cfg_q.d_gain    <= cfg.data[GAIN_W-1:0];
				REG_SEP_LIMIT: cfg_q.sep_limit <= cfg.data[SEP_W-1:0];
				REG_INT_LIMIT: cfg_q.int_limit <= cfg.data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	pid_is_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.cfg_regs  (cfg_q),
		.valid_s1  (valid_s1),
		.nxt_ready (ready_s1),
		.data_s1   (data_s1),
		.stat      (stat)
	);

	pid_is_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_q),
		.valid_s1  (valid_s1),
		.ready_s1  (ready_s1),
		.data_s1   (data_s1),
		.valid_s2  (valid_s2),
		.nxt_ready (ready_s2),
		.data_s2   (data_s2)
	);

	pid_is_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.data_s2  (data_s2),
		.result   (result)
	);

	assign accept = sample.valid && sample.ready;
	assign armed  = (sample.arm_code == ARM_CODE) && (sample.throttle >= THROTTLE_MIN);

	`PIS_ASSERT_NEXT(a_disarm_clears, clk, arst_n, accept && !armed, stat.integral == '0, "integral not cleared while disarmed")
	`PIS_ASSERT_NEXT(a_prev_error, clk, arst_n, accept, stat.prev_error == data_s1.error, "previous error differs from the captured error")
	`PIS_ASSERT_IMPLY(a_iterm_zero, clk, arst_n, result.valid && !result.integrating, result.i_term == '0, "I term nonzero outside integration")
endmodule

// ===== bench/pid_integral_separation_tb.sv =====
`timescale 1ns / 100ps

module pid_integral_separation_tb;
	import pid_is_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_SAMPLES = 150;
	localparam longint DRIVE_MAX = 64'sd2147483647;
	localparam longint DRIVE_MIN = -DRIVE_MAX - 1;

	typedef struct packed {
		logic signed [15:0] target;
		logic signed [15:0] measure;
		logic [7:0]         arm_code;
		logic [11:0]        throttle;
	} sample_t;

	typedef enum logic [1:0] {
		STEP_SAMPLE,
		STEP_WRITE,
		STEP_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		sample_t          smp;
		logic [IDX_W-1:0] idx;
		logic [CFG_W-1:0] data;
		int               odds;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	pid_is_in_if  sample_if ();
	pid_is_out_if result_if ();
	pid_is_cfg_if cfg_if ();

	pid_integral_separation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	step_t   step_plan[$];
	res_t    predicted[$];
	sample_t on_wire;
	int      plan_odds;
	int      plan_sep;
	int      idle_odds;
	int      gap_left;
	int      stall_left;
	int      idle_cycles;
	int      mismatches;

	// Controller state as the block should hold it.
	logic [GAIN_W-1:0]         k_p;
	logic [GAIN_W-1:0]         k_i;
	logic [GAIN_W-1:0]         k_d;
	logic [SEP_W-1:0]          sep_band;
	logic [LIM_W-1:0]          int_clamp;
	logic signed [ERR_W-1:0]   last_error;
	logic signed [INTEG_W-1:0] integral_acc;

	function automatic logic signed [OUT_W-1:0] drop_frac(longint v);
		longint q;
		q = v >>> FRAC_W;
		return q[OUT_W-1:0];
	endfunction

	function automatic res_t predict_control(sample_t s);
		logic signed [15:0] tgt;
		logic signed [15:0] meas;
		longint err;
		longint dif;
		longint acc;
		longint sep_l;
		longint lim_l;
		longint p_full;
		longint i_full;
		longint d_full;
		longint total;
		logic armed;
		logic inband;
		res_t r;
		tgt = s.target;
		meas = s.measure;
		err = longint'(tgt) - longint'(meas);
		dif = err - longint'(last_error);
		sep_l = longint'(sep_band);
		lim_l = longint'(int_clamp);
		armed = (s.arm_code == ARM_CODE) && (s.throttle >= THROTTLE_MIN);
		inband = armed && (longint'(meas) <= sep_l) && (longint'(meas) >= -sep_l);
		if (!armed) begin
			integral_acc = '0;
		end else if (inband) begin
			acc = longint'(integral_acc) + err;
			if (acc > lim_l)
				acc = lim_l;
			if (acc < -lim_l)
				acc = -lim_l;
			integral_acc = acc[INTEG_W-1:0];
		end
		p_full = longint'(k_p) * err;
		i_full = inband ? longint'(k_i) * longint'(integral_acc) : 64'sd0;
		d_full = longint'(k_d) * dif;
		total = (p_full + i_full + d_full) >>> FRAC_W;
		if (total > DRIVE_MAX)
			total = DRIVE_MAX;
		if (total < DRIVE_MIN)
			total = DRIVE_MIN;
		r.drive = total[OUT_W-1:0];
		r.p_term = drop_frac(p_full);
		r.i_term = drop_frac(i_full);
		r.d_term = drop_frac(d_full);
		r.integrating = inband;
		last_error = err[ERR_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		mismatches++;
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
	endtask

	task automatic push_sample(int t, int m, int arm, int thr);
		step_t st;
		st.kind = STEP_SAMPLE;
		st.smp.target = t[15:0];
		st.smp.measure = m[15:0];
		st.smp.arm_code = arm[7:0];
		st.smp.throttle = thr[11:0];
		st.idx = '0;
		st.data = '0;
		st.odds = plan_odds;
		step_plan.push_back(st);
	endtask

	task automatic push_step(step_kind_t kind, logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		step_t st;
		st.kind = kind;
		st.smp = '0;
		st.idx = idx;
		st.data = data;
		st.odds = plan_odds;
		step_plan.push_back(st);
	endtask

	// Waits for the pipeline to empty, then rewrites every register. Spare bits above
	// each register's width are filled with junk, and an unmapped index is written too.
	task automatic plan_config(int p, int i, int d, int sep, int lim);
		push_step(STEP_DRAIN, '0, '0);
		push_step(STEP_WRITE, REG_P_GAIN, {4'($urandom_range(0, 15)), 16'(p)});
		push_step(STEP_WRITE, REG_I_GAIN, {4'($urandom_range(0, 15)), 16'(i)});
		push_step(STEP_WRITE, REG_D_GAIN, {4'($urandom_range(0, 15)), 16'(d)});
		push_step(STEP_WRITE, REG_SEP_LIMIT, {5'($urandom_range(0, 31)), 15'(sep)});
		push_step(STEP_WRITE, REG_INT_LIMIT, 20'(lim));
		push_step(STEP_WRITE, REG_SPARE, 20'($urandom));
		plan_sep = sep;
	endtask

	// Mostly armed samples near the separation band, with some noise on the arm inputs.
	task automatic plan_random_sample();
		int t;
		int m;
		int arm;
		int thr;
		int roll;
		arm = ARM_CODE;
		thr = $urandom_range(THROTTLE_MIN, 4095);
		roll = $urandom_range(0, 9);
		if (roll == 0)
			arm = $urandom_range(0, 255);
		else if (roll == 1)
			thr = $urandom_range(0, THROTTLE_MIN);
		if ($urandom_range(0, 3) == 0)
			m = int'($urandom_range(0, 65535)) - 32768;
		else
			m = int'($urandom_range(0, 2 * plan_sep)) - plan_sep;
		if ($urandom_range(0, 3) == 0) begin
			t = int'($urandom_range(0, 65535)) - 32768;
		end else begin
			t = m + int'($urandom_range(0, 600)) - 300;
			if (t > 32767)
				t = 32767;
			if (t < -32768)
				t = -32768;
		end
		push_sample(t, m, arm, thr);
	endtask

	always @(posedge clk) begin : drive_stimulus
		logic s_valid;
		logic c_valid;
		step_t head;
		s_valid = sample_if.valid;
		c_valid = cfg_if.valid;
		if (arst_n) begin
			if (sample_if.valid && sample_if.ready) begin
				predicted.push_back(predict_control(on_wire));
				s_valid = 1'b0;
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_P_GAIN:    k_p = cfg_if.data[GAIN_W-1:0];
					REG_I_GAIN:    k_i = cfg_if.data[GAIN_W-1:0];
					REG_D_GAIN:    k_d = cfg_if.data[GAIN_W-1:0];
					REG_SEP_LIMIT: sep_band = cfg_if.data[SEP_W-1:0];
					REG_INT_LIMIT: int_clamp = cfg_if.data[LIM_W-1:0];
					default: ;
				endcase
				c_valid = 1'b0;
			end
			if (gap_left != 0) begin
				gap_left--;
			end else if (!s_valid && !c_valid && step_plan.size() != 0) begin
				head = step_plan[0];
				idle_odds <= head.odds;
				case (head.kind)
					STEP_SAMPLE: begin
						if (head.odds != 0 && $urandom_range(1, head.odds) == 1) begin
							gap_left = $urandom_range(1, 12);
						end else begin
							void'(step_plan.pop_front());
							on_wire = head.smp;
							sample_if.target <= head.smp.target;
							sample_if.measure <= head.smp.measure;
							sample_if.arm_code <= head.smp.arm_code;
							sample_if.throttle <= head.smp.throttle;
							s_valid = 1'b1;
						end
					end
					STEP_WRITE: begin
						void'(step_plan.pop_front());
						cfg_if.index <= head.idx;
						cfg_if.data <= head.data;
						c_valid = 1'b1;
					end
					default: begin
						// Registers change only once every outstanding result is out.
						if (predicted.size() == 0)
							void'(step_plan.pop_front());
					end
				endcase
			end
		end
		sample_if.valid <= s_valid;
		cfg_if.valid <= c_valid;
	end

	always @(posedge clk) begin : check_output
		res_t want;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				if (predicted.size() == 0) begin
					report_mismatch("result with nothing pending, drive", result_if.drive, 0);
				end else begin
					want = predicted.pop_front();
					if (result_if.drive !== want.drive)
						report_mismatch("drive", result_if.drive, want.drive);
					if (result_if.p_term !== want.p_term)
						report_mismatch("p_term", result_if.p_term, want.p_term);
					if (result_if.i_term !== want.i_term)
						report_mismatch("i_term", result_if.i_term, want.i_term);
					if (result_if.d_term !== want.d_term)
						report_mismatch("d_term", result_if.d_term, want.d_term);
					if (result_if.integrating !== want.integrating)
						report_mismatch("integrating", result_if.integrating, want.integrating);
				end
			end
			if (stall_left != 0)
				stall_left--;
			else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
				stall_left = $urandom_range(1, 12);
			result_if.ready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_if.valid = 1'b0;
		sample_if.target = '0;
		sample_if.measure = '0;
		sample_if.arm_code = '0;
		sample_if.throttle = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		result_if.ready = 1'b0;
		on_wire = '0;
		gap_left = 0;
		stall_left = 0;
		idle_cycles = 0;
		idle_odds = 4;
		mismatches = 0;
		k_p = '0;
		k_i = '0;
		k_d = '0;
		sep_band = '0;
		int_clamp = '0;
		last_error = '0;
		integral_acc = '0;
		plan_odds = 4;
		plan_sep = 0;

		// Unity P gain, band of 1000, integral clamp of 5000.
		plan_config(16'h0100, 16'h0080, 16'h0200, 1000, 5000);
		push_sample(500, 1000, ARM_CODE, THROTTLE_MIN);
		push_sample(-500, -1000, ARM_CODE, THROTTLE_MIN);
		push_sample(0, 1001, ARM_CODE, 4095);
		push_sample(0, -1001, ARM_CODE, 4095);
		push_sample(32767, 0, ARM_CODE, 300);
		push_sample(32767, 0, ARM_CODE, 300);
		push_sample(0, 0, ARM_CODE, THROTTLE_MIN - 1);
		push_sample(-32768, 0, ARM_CODE, 300);
		push_sample(100, 50, ARM_CODE + 1, 4095);
		push_sample(32767, -32768, ARM_CODE, 4095);
		push_sample(-32768, 32767, 255, 0);
		push_sample(4000, 0, ARM_CODE, 4095);
		// Lowering the clamp must not touch the held integral until it integrates again.
		plan_config(16'h0100, 16'h0080, 16'h0200, 1000, 100);
		push_sample(0, 2000, ARM_CODE, 4095);
		push_sample(10, 0, ARM_CODE, 4095);
		plan_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32767, 20'hFFFFF);
		push_sample(32767, -32768, ARM_CODE, 4095);
		push_sample(-32768, 32767, ARM_CODE, 4095);
		push_sample(32767, -32767, ARM_CODE, 4095);
		push_sample(32767, 0, ARM_CODE, 4095);
		plan_config(0, 0, 0, 0, 0);
		push_sample(5, 0, ARM_CODE, 4095);
		push_sample(5, 1, ARM_CODE, 4095);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph % 4)
				0: begin
					plan_odds = 4;
					plan_config($urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 32767),
						$urandom_range(0, 20'hFFFFF));
				end
				1: begin
					plan_odds = 10;
					plan_config($urandom_range(0, 65535), $urandom_range(0, 65535),
						$urandom_range(0, 65535), $urandom_range(0, 300),
						$urandom_range(0, 2000));
				end
				2: begin
					plan_odds = 0;
					plan_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 32767, 20'hFFFFF);
				end
				default: begin
					plan_odds = 6;
					plan_config($urandom_range(0, 1024), $urandom_range(0, 1024),
						$urandom_range(0, 1024), $urandom_range(0, 4000),
						$urandom_range(0, 60000));
				end
			endcase
			if (ph == RANDOM_PHASES - 1)
				plan_odds = 0;
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				if ($urandom_range(0, 60) == 0)
					push_step(STEP_DRAIN, '0, '0);
				plan_random_sample();
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (step_plan.size() != 0 || sample_if.valid || cfg_if.valid || predicted.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
